[sv/ple_pkg.sv]
// ple_pkg: request kind codes, result status codes and field widths
// for the positional list engine. No dependencies.
package ple_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [2:0] KIND_PUSH_FRONT   = 3'd0;
  localparam logic [2:0] KIND_APPEND       = 3'd1;
  localparam logic [2:0] KIND_INSERT_AFTER = 3'd2;
  localparam logic [2:0] KIND_READ         = 3'd3;
  localparam logic [2:0] KIND_FIND         = 3'd4;
  localparam logic [2:0] KIND_REMOVE       = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

[sv/ple_store.sv]
// ple_store: entry storage, one write port and one read port,
// registered read data. Depends on ple_pkg for the data width.
module ple_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [ple_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [ple_pkg::DATA_W-1:0] rdata
);

  logic [ple_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/positional_list_engine_top.sv]
// Append and rejected requests: done is raised in the cycle after accept. Read: done
// follows the READ_WAIT state. Push front, insert-after, remove: SHIFT moves the entries
// behind the position, if any. Find: FIND scans from the front and stops at the first
// match; a miss scans every entry. Both are bound by the single store read port: one
// entry moved or compared a cycle. Synchronous reset empties the list.
// Results are strobed by done for one cycle; the receiver cannot stall.
module positional_list_engine_top #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          kind,
  input  logic [ple_pkg::POS_W-1:0]           position,
  input  logic signed [ple_pkg::DATA_W-1:0]   item_value,
  output logic                                done,
  output logic [1:0]                          status,
  output logic signed [ple_pkg::DATA_W-1:0]   read_value,
  output logic [ple_pkg::POS_W-1:0]           found_position,
  output logic [ple_pkg::COUNT_W-1:0]         entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
  localparam int EW = (CW > ple_pkg::COUNT_W) ? CW : ple_pkg::COUNT_W;
  localparam int FW = (AW > ple_pkg::POS_W) ? AW : ple_pkg::POS_W;

  typedef enum logic [1:0] {IDLE, SHIFT, FIND, READ_WAIT} state_t;

  state_t                     state;
  logic                       insert;
  logic [ple_pkg::DATA_W-1:0] val;
  logic [AW-1:0]              at;
  logic [CW-1:0]              src;
  logic [CW-1:0]              left;
  logic                       pend;
  logic [AW-1:0]              pend_addr;
  logic [CW-1:0]              count;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [ple_pkg::DATA_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [ple_pkg::DATA_W-1:0] rdata;

  logic [PW-1:0]              pos_ext;
  logic                       pos_ok;
  logic                       full;
  logic [CW-1:0]              count_next;

  function automatic logic [ple_pkg::COUNT_W-1:0] count_out(input logic [CW-1:0] c);
    logic [EW-1:0] e;
    e = EW'(c);
    return e[ple_pkg::COUNT_W-1:0];
  endfunction

  function automatic logic [ple_pkg::POS_W-1:0] pos_out(input logic [AW-1:0] a);
    logic [FW-1:0] f;
    f = FW'(a);
    return f[ple_pkg::POS_W-1:0];
  endfunction

  assign busy    = (state != IDLE);
  assign pos_ext = PW'(position);
  assign pos_ok  = pos_ext < PW'(count);
  assign full    = (count == CW'(CAPACITY));

  ple_store #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Shifts read one entry ahead of the write; read and write never hit
  // the same entry in one cycle.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val;
    re    = 1'b0;
    raddr = src[AW-1:0];
    case (state)
      IDLE: begin
        if (start && kind == ple_pkg::KIND_APPEND && !full) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wdata = item_value;
        end
        if (start && kind == ple_pkg::KIND_READ && pos_ok) begin
          re    = 1'b1;
          raddr = pos_ext[AW-1:0];
        end
      end
      SHIFT: begin
        re = (left != '0);
        if (pend) begin
          we    = 1'b1;
          waddr = insert ? pend_addr + AW'(1) : pend_addr - AW'(1);
          wdata = rdata;
        end else if (left == '0) begin
          we    = insert;
          waddr = at;
          wdata = val;
        end
      end
      FIND: begin
        re = (left != '0);
      end
      default: begin
      end
    endcase
  end

  assign count_next = insert ? count + CW'(1) : count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            val            <= item_value;
            pend           <= 1'b0;
            read_value     <= '0;
            found_position <= '0;
            entry_count    <= count_out(count);
            case (kind)
              ple_pkg::KIND_PUSH_FRONT: begin
                if (full) begin
                  done   <= 1'b1;
                  status <= ple_pkg::ST_FULL;
                end else begin
                  insert <= 1'b1;
                  at     <= '0;
                  left   <= count;
                  src    <= count - CW'(1);
                  state  <= SHIFT;
                end
              end
              ple_pkg::KIND_APPEND: begin
                done <= 1'b1;
                if (full) begin
                  status <= ple_pkg::ST_FULL;
                end else begin
                  status      <= ple_pkg::ST_OK;
                  count       <= count + CW'(1);
                  entry_count <= count_out(count + CW'(1));
                end
              end
              ple_pkg::KIND_INSERT_AFTER: begin
                if (!pos_ok) begin
                  done   <= 1'b1;
                  status <= ple_pkg::ST_RANGE;
                end else if (full) begin
                  done   <= 1'b1;
                  status <= ple_pkg::ST_FULL;
                end else begin
                  insert <= 1'b1;
                  at     <= pos_ext[AW-1:0] + AW'(1);
                  left   <= count - pos_ext[CW-1:0] - CW'(1);
                  src    <= count - CW'(1);
                  state  <= SHIFT;
                end
              end
              ple_pkg::KIND_READ: begin
                if (!pos_ok) begin
                  done   <= 1'b1;
                  status <= ple_pkg::ST_RANGE;
                end else begin
                  state <= READ_WAIT;
                end
              end
              ple_pkg::KIND_FIND: begin
                left  <= count;
                src   <= '0;
                state <= FIND;
              end
              ple_pkg::KIND_REMOVE: begin
                if (!pos_ok) begin
                  done   <= 1'b1;
                  status <= ple_pkg::ST_RANGE;
                end else begin
                  insert <= 1'b0;
                  left   <= count - pos_ext[CW-1:0] - CW'(1);
                  src    <= pos_ext[CW-1:0] + CW'(1);
                  state  <= SHIFT;
                end
              end
              default: begin
                done   <= 1'b1;
                status <= ple_pkg::ST_RANGE;
              end
            endcase
          end
        end
        SHIFT: begin
          if (left != '0) begin
            src       <= insert ? src - CW'(1) : src + CW'(1);
            left      <= left - CW'(1);
            pend      <= 1'b1;
            pend_addr <= src[AW-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (!pend && left == '0) begin
            count       <= count_next;
            done        <= 1'b1;
            status      <= ple_pkg::ST_OK;
            entry_count <= count_out(count_next);
            state       <= IDLE;
          end
        end
        FIND: begin
          if (pend && rdata == val) begin
            pend           <= 1'b0;
            done           <= 1'b1;
            status         <= ple_pkg::ST_OK;
            found_position <= pos_out(pend_addr);
            state          <= IDLE;
          end else begin
            if (left != '0) begin
              src       <= src + CW'(1);
              left      <= left - CW'(1);
              pend      <= 1'b1;
              pend_addr <= src[AW-1:0];
            end else begin
              pend <= 1'b0;
            end
            if (!pend && left == '0) begin
              done   <= 1'b1;
              status <= ple_pkg::ST_RANGE;
              state  <= IDLE;
            end
          end
        end
        READ_WAIT: begin
          done       <= 1'b1;
          status     <= ple_pkg::ST_OK;
          read_value <= rdata;
          state      <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[sv/ple_checker.sv]
// ple_checker: port-level checks on the positional list engine, bound to
// positional_list_engine_top. Depends on ple_pkg for status codes.
module ple_checker #(
  parameter int CAPACITY = 64
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [1:0]                        status,
  input logic signed [ple_pkg::DATA_W-1:0] read_value,
  input logic [ple_pkg::POS_W-1:0]         found_position,
  input logic [ple_pkg::COUNT_W-1:0]       entry_count
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while engine busy");

  a_request_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted request neither started nor finished");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ple_pkg::ST_OK |-> read_value == '0 && found_position == '0)
    else $error("rejected request returned data");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ple_pkg::ST_FULL |-> entry_count == ple_pkg::COUNT_W'(CAPACITY))
    else $error("full status with list not full");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) && status != ple_pkg::ST_OK && $past(status) != ple_pkg::ST_OK
      |-> entry_count == $past(entry_count))
    else $error("rejected request changed the count");

endmodule

bind positional_list_engine_top ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .read_value    (read_value),
  .found_position(found_position),
  .entry_count   (entry_count)
);

[tb/sv/tb_positional_list_engine_top.sv]
// Self-checking testbench for positional_list_engine_top: list requests go in
// over start/busy, each done-strobed result is checked against a local list model.
// Depends on ple_pkg and the positional_list_engine_top RTL.
module tb_positional_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 64;
  localparam int SETTLE_CYCLES = CAPACITY + 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_REQUESTS = 850;

  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  typedef struct {
    logic [1:0]                  status;
    logic [ple_pkg::DATA_W-1:0]  read_value;
    logic [ple_pkg::POS_W-1:0]   found_position;
    logic [ple_pkg::COUNT_W-1:0] entry_count;
  } list_result_t;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic [2:0]                        kind;
  logic [ple_pkg::POS_W-1:0]         position;
  logic signed [ple_pkg::DATA_W-1:0] item_value;
  logic                              done;
  logic [1:0]                        status;
  logic signed [ple_pkg::DATA_W-1:0] read_value;
  logic [ple_pkg::POS_W-1:0]         found_position;
  logic [ple_pkg::COUNT_W-1:0]       entry_count;

  logic [ple_pkg::DATA_W-1:0] list_entries [CAPACITY];
  int                         list_count;
  list_result_t               pending_results [$];
  list_result_t               oldest_result;
  int                         error_count;
  int                         cycle_count;
  bit                         back_to_back;

  positional_list_engine_top #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .position(position), .item_value(item_value),
    .done(done), .status(status), .read_value(read_value),
    .found_position(found_position), .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic list_result_t apply_list_request(
      input logic [2:0] req_kind,
      input logic [ple_pkg::POS_W-1:0] req_pos,
      input logic [ple_pkg::DATA_W-1:0] req_value);
    list_result_t r;
    int i;
    bit hit;
    r.status = ple_pkg::ST_OK;
    r.read_value = '0;
    r.found_position = '0;
    hit = 1'b0;
    case (req_kind)
      ple_pkg::KIND_PUSH_FRONT: begin
        if (list_count >= CAPACITY) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          for (i = list_count; i > 0; i--) list_entries[i] = list_entries[i-1];
          list_entries[0] = req_value;
          list_count++;
        end
      end
      ple_pkg::KIND_APPEND: begin
        if (list_count >= CAPACITY) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          list_entries[list_count] = req_value;
          list_count++;
        end
      end
      ple_pkg::KIND_INSERT_AFTER: begin
        if (int'(req_pos) >= list_count) begin
          r.status = ple_pkg::ST_RANGE;
        end else if (list_count >= CAPACITY) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          for (i = list_count; i > int'(req_pos) + 1; i--) list_entries[i] = list_entries[i-1];
          list_entries[int'(req_pos) + 1] = req_value;
          list_count++;
        end
      end
      ple_pkg::KIND_READ: begin
        if (int'(req_pos) >= list_count) r.status = ple_pkg::ST_RANGE;
        else r.read_value = list_entries[req_pos];
      end
      ple_pkg::KIND_FIND: begin
        for (i = 0; i < list_count && !hit; i++) begin
          if (list_entries[i] == req_value) begin
            hit = 1'b1;
            r.found_position = i[ple_pkg::POS_W-1:0];
          end
        end
        if (!hit) r.status = ple_pkg::ST_RANGE;
      end
      ple_pkg::KIND_REMOVE: begin
        if (int'(req_pos) >= list_count) begin
          r.status = ple_pkg::ST_RANGE;
        end else begin
          for (i = int'(req_pos); i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
          list_count--;
        end
      end
      default: r.status = ple_pkg::ST_RANGE;
    endcase
    r.entry_count = list_count[ple_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_request(input logic [2:0] req_kind,
                              input logic [ple_pkg::POS_W-1:0] req_pos,
                              input logic [ple_pkg::DATA_W-1:0] req_value);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    kind       <= req_kind;
    position   <= req_pos;
    item_value <= req_value;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_request(req_kind, req_pos, req_value));
  endtask

  function automatic logic [ple_pkg::DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return $urandom();
    if (sel < 75) return ple_pkg::DATA_W'($urandom_range(0, 7)) - ple_pkg::DATA_W'(4);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [ple_pkg::DATA_W-1:0] pick_search_value();
    if (list_count > 0 && $urandom_range(0, 9) < 7)
      return list_entries[$urandom_range(0, list_count - 1)];
    return pick_value();
  endfunction

  function automatic logic [ple_pkg::POS_W-1:0] pick_position();
    int sel;
    sel = $urandom_range(0, 99);
    if (list_count > 0 && sel < 80) return ple_pkg::POS_W'($urandom_range(0, list_count - 1));
    if (list_count < CAPACITY && sel < 88) return ple_pkg::POS_W'(list_count);
    return ple_pkg::POS_W'($urandom_range(0, CAPACITY - 1));
  endfunction

  function automatic logic [2:0] pick_kind(input bit grow);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 2) return $urandom_range(0, 1) ? KIND_UNUSED_6 : KIND_UNUSED_7;
    if (grow) begin
      if (sel < 20) return ple_pkg::KIND_PUSH_FRONT;
      if (sel < 40) return ple_pkg::KIND_APPEND;
      if (sel < 60) return ple_pkg::KIND_INSERT_AFTER;
      if (sel < 75) return ple_pkg::KIND_READ;
      if (sel < 90) return ple_pkg::KIND_FIND;
      return ple_pkg::KIND_REMOVE;
    end
    if (sel < 10) return ple_pkg::KIND_PUSH_FRONT;
    if (sel < 15) return ple_pkg::KIND_APPEND;
    if (sel < 20) return ple_pkg::KIND_INSERT_AFTER;
    if (sel < 35) return ple_pkg::KIND_READ;
    if (sel < 50) return ple_pkg::KIND_FIND;
    return ple_pkg::KIND_REMOVE;
  endfunction

  task automatic send_random_request(input bit grow);
    logic [2:0] k;
    k = pick_kind(grow);
    send_request(k, pick_position(),
                 (k == ple_pkg::KIND_FIND) ? pick_search_value() : pick_value());
  endtask

  task automatic test_empty_list();
    send_request(ple_pkg::KIND_READ, 6'd0, '0);
    send_request(ple_pkg::KIND_READ, 6'd63, '0);
    send_request(ple_pkg::KIND_REMOVE, 6'd0, '0);
    send_request(ple_pkg::KIND_INSERT_AFTER, 6'd0, 32'h1234_5678);
    send_request(ple_pkg::KIND_FIND, 6'd0, 32'h0000_0000);
    send_request(KIND_UNUSED_6, 6'd63, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED_7, 6'd0, 32'h8000_0000);
  endtask

  task automatic test_basic_ops();
    send_request(ple_pkg::KIND_PUSH_FRONT, 6'd0, 32'h7FFF_FFFF);
    send_request(ple_pkg::KIND_APPEND, 6'd63, 32'h8000_0000);
    send_request(ple_pkg::KIND_INSERT_AFTER, 6'd0, 32'h0000_0000);
    send_request(ple_pkg::KIND_INSERT_AFTER, 6'd2, 32'hFFFF_FFFF);
    send_request(ple_pkg::KIND_INSERT_AFTER, 6'd4, 32'h5555_AAAA);
    send_request(ple_pkg::KIND_READ, 6'd0, '0);
    send_request(ple_pkg::KIND_READ, 6'd3, '0);
    send_request(ple_pkg::KIND_READ, 6'd4, '0);
    send_request(ple_pkg::KIND_FIND, 6'd0, 32'h8000_0000);
    send_request(ple_pkg::KIND_FIND, 6'd0, 32'h0001_2345);
    // duplicate value: find must return the first match
    send_request(ple_pkg::KIND_PUSH_FRONT, 6'd0, 32'h0000_0000);
    send_request(ple_pkg::KIND_FIND, 6'd63, 32'h0000_0000);
    send_request(ple_pkg::KIND_REMOVE, 6'd4, '0);
    send_request(ple_pkg::KIND_REMOVE, 6'd0, '0);
    send_request(ple_pkg::KIND_REMOVE, 6'd5, '0);
    send_request(ple_pkg::KIND_READ, 6'd2, '0);
  endtask

  task automatic test_full_list();
    logic [2:0] k;
    while (list_count < CAPACITY) begin
      case ($urandom_range(0, 2))
        0: k = ple_pkg::KIND_PUSH_FRONT;
        1: k = ple_pkg::KIND_APPEND;
        default: k = ple_pkg::KIND_INSERT_AFTER;
      endcase
      send_request(k,
                   ple_pkg::POS_W'($urandom_range(0, (list_count > 0) ? list_count - 1 : 0)),
                   pick_value());
    end
    send_request(ple_pkg::KIND_PUSH_FRONT, 6'd0, pick_value());
    send_request(ple_pkg::KIND_APPEND, 6'd0, pick_value());
    send_request(ple_pkg::KIND_INSERT_AFTER, 6'd63, pick_value());
    send_request(ple_pkg::KIND_INSERT_AFTER, 6'd0, pick_value());
    send_request(ple_pkg::KIND_READ, 6'd63, '0);
    send_request(ple_pkg::KIND_FIND, 6'd0, list_entries[CAPACITY-1]);
    send_request(ple_pkg::KIND_REMOVE, 6'd63, '0);
    send_request(ple_pkg::KIND_APPEND, 6'd0, 32'h7FFF_FFFF);
  endtask

  task automatic test_random_mix();
    bit grow;
    int n;
    grow = 1'b0;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      if (list_count == 0) grow = 1'b1;
      else if (list_count >= CAPACITY && $urandom_range(0, 7) == 0) grow = 1'b0;
      send_random_request(grow);
    end
    back_to_back = 1'b0;
  endtask

  task automatic test_drain();
    while (list_count > 0) begin
      send_request(ple_pkg::KIND_REMOVE, ple_pkg::POS_W'($urandom_range(0, list_count - 1)),
                   pick_value());
    end
    send_request(ple_pkg::KIND_READ, 6'd0, '0);
    send_request(ple_pkg::KIND_FIND, 6'd0, 32'h8000_0000);
    send_request(ple_pkg::KIND_APPEND, 6'd0, 32'hFFFF_FFFF);
  endtask

  task automatic compare_field(input string field_name,
                               input logic [ple_pkg::DATA_W-1:0] expected_bits,
                               input logic [ple_pkg::DATA_W-1:0] actual_bits);
    if (actual_bits !== expected_bits) begin
      error_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field_name,
               expected_bits, actual_bits);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual status %0d count %0d",
                 $time, status, entry_count);
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("status", ple_pkg::DATA_W'(oldest_result.status),
                      ple_pkg::DATA_W'(status));
        compare_field("read_value", oldest_result.read_value, read_value);
        compare_field("found_position", ple_pkg::DATA_W'(oldest_result.found_position),
                      ple_pkg::DATA_W'(found_position));
        compare_field("entry_count", ple_pkg::DATA_W'(oldest_result.entry_count),
                      ple_pkg::DATA_W'(entry_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    kind         = ple_pkg::KIND_PUSH_FRONT;
    position     = '0;
    item_value   = '0;
    list_count   = 0;
    error_count  = 0;
    cycle_count  = 0;
    back_to_back = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_mix();
    test_drain();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
